>>> rtl/core/lock_pulse_cooldown_controller_macros.svh
// Assertion macros shared by the lock pulse/cooldown controller RTL.
// Every macro expects a clock named clk_i and an active-low reset named rst_ni.
`ifndef LOCK_PULSE_COOLDOWN_CONTROLLER_MACROS_SVH
`define LOCK_PULSE_COOLDOWN_CONTROLLER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LPCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define LPCC_ASSERT_NEVER(lbl, cond, msg) \
  `LPCC_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/lpcc_pkg.sv
// Shared types and constants of the lock pulse/cooldown controller.
// Has no dependencies; every other RTL file of the block but lpcc_fifo uses it.
package lpcc_pkg;

  // Command codes of the request op field.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_OPEN    = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Reason codes of a report.
  localparam logic [2:0] REASON_OPEN          = 3'd0;
  localparam logic [2:0] REASON_CLOSE         = 3'd1;
  localparam logic [2:0] REASON_PULSE_DONE    = 3'd2;
  localparam logic [2:0] REASON_COOLDOWN_DONE = 3'd3;
  localparam logic [2:0] REASON_DISABLED      = 3'd4;
  localparam logic [2:0] REASON_BUSY          = 3'd5;
  localparam logic [2:0] REASON_WRONG_MODE    = 3'd6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FS_MASK      = 2'd2;

  localparam logic [15:0] PULSE_LEN_RESET    = 16'd500;
  localparam logic [15:0] COOLDOWN_LEN_RESET = 16'd1000;
  localparam logic [7:0]  FS_MASK_RESET      = 8'd0;

  // Locks that a 3-bit index and the 8-bit mode mask can reach.
  localparam int unsigned MAX_ADDR_LOCKS = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  lock_index;
    logic [31:0] now_ms;
    logic        node_enabled;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_lock;
    logic [2:0]  reason_code;
    logic        coil_on;
    logic [15:0] pulse_total;
    logic [7:0]  coil_levels;
    logic        last;
  } res_item_t;

  // Classified request handed from the front end to the executor.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_DISABLED,
    CMD_WRONG_MODE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  lock;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

>>> rtl/core/lpcc_fifo.sv
// Small first-in first-out queue of fixed-width words.
// Depends on the assertion macro header only.
`include "lock_pulse_cooldown_controller_macros.svh"

module lpcc_fifo #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LPCC_ASSERT(a_fifo_count_bound, cnt_q <= CNT_W'(DEPTH), "fifo count exceeds depth")
  `LPCC_ASSERT(a_fifo_write_fills, (wr_en && !rd_en) |=> !empty_o, "write lost in fifo")
  `LPCC_ASSERT(a_fifo_read_drains, (rd_en && !wr_en && cnt_q == CNT_W'(1)) |=> empty_o, "fifo not drained")

endmodule

>>> rtl/core/lpcc_front.sv
// Front end: accepts requests, drops unaddressable commands and classifies the rest.
// Depends on lpcc_pkg and lpcc_fifo.
module lpcc_front #(
  parameter int unsigned NUM_LOCKS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpcc_pkg::in_item_t  item_i,
  output logic                full_o,
  input  logic                cmd_pop_i,
  output logic                cmd_empty_o,
  output lpcc_pkg::cmd_t      cmd_o
);

  localparam int unsigned CMD_W = $bits(lpcc_pkg::cmd_t);

  lpcc_pkg::cmd_t   cmd_in;
  logic             lock_ok;
  logic             drop;
  logic [CMD_W-1:0] cmd_rdata;

  // A command to a lock that does not exist is consumed without a report.
  assign lock_ok = (32'(item_i.lock_index) < 32'(NUM_LOCKS));
  assign drop    = (item_i.op != lpcc_pkg::OP_TICK) && !lock_ok;

  always_comb begin
    cmd_in.lock   = item_i.lock_index;
    cmd_in.now_ms = item_i.now_ms;
    if (item_i.op == lpcc_pkg::OP_TICK) begin
      cmd_in.kind = lpcc_pkg::CMD_TICK;
    end else if (!item_i.node_enabled) begin
      cmd_in.kind = lpcc_pkg::CMD_DISABLED;
    end else begin
      unique case (item_i.op)
        lpcc_pkg::OP_OPEN:  cmd_in.kind = lpcc_pkg::CMD_OPEN;
        lpcc_pkg::OP_CLOSE: cmd_in.kind = lpcc_pkg::CMD_CLOSE;
        default:            cmd_in.kind = lpcc_pkg::CMD_WRONG_MODE;
      endcase
    end
  end

  lpcc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i && !drop),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .rd_i    (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = lpcc_pkg::cmd_t'(cmd_rdata);

endmodule

>>> rtl/core/lpcc_back.sv
// Executor: holds configuration and per-lock state, runs commands and tick scans.
// Depends on lpcc_pkg and the assertion macro header.
`include "lock_pulse_cooldown_controller_macros.svh"

module lpcc_back #(
  parameter int unsigned NUM_LOCKS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpcc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lpcc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                cmd_empty_i,
  input  lpcc_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output lpcc_pkg::res_item_t                 res_o
);

  // Locks beyond the mask width are always fail-safe and unaddressable.
  localparam int unsigned L = (NUM_LOCKS < lpcc_pkg::MAX_ADDR_LOCKS) ?
                              NUM_LOCKS : lpcc_pkg::MAX_ADDR_LOCKS;
  localparam int unsigned IDX_W = (L > 1) ? $clog2(L) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_CMD_OUT = 3'd2;
  localparam logic [2:0] S_EVAL    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]       state_q, state_d;
  lpcc_pkg::cmd_t   cmd_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             sub_q, sub_d;
  logic [L-1:0]     pmask_q, pmask_d;
  logic [L-1:0]     cmask_q, cmask_d;
  logic [2:0]       reason_q, reason_d;

  logic [15:0]      plen_q, clen_q;
  logic [7:0]       fsm_q;

  logic [L-1:0]     coil_q, pact_q, cact_q;
  logic [31:0]      pst_q [L];
  logic [31:0]      cst_q [L];
  logic [15:0]      pcnt_q [L];

  logic [L-1:0]     fs_vec;
  logic [IDX_W-1:0] cmd_idx, rd_idx;
  logic             exec_fs, exec_busy;
  logic [31:0]      pel, cel;
  logic             ev_fs, pdone, cdone;
  logic             in_scan;
  logic             ev_here, more, at_end;
  logic [L-1:0]     above;

  assign fs_vec    = fsm_q[L-1:0];
  assign cmd_idx   = cmd_q.lock[IDX_W-1:0];
  assign in_scan   = (state_q == S_EVAL) || (state_q == S_EMIT);
  assign rd_idx    = in_scan ? idx_q : cmd_idx;
  assign exec_fs   = fs_vec[cmd_idx];
  assign exec_busy = pact_q[cmd_idx] || cact_q[cmd_idx];
  assign at_end    = (idx_q == IDX_W'(L - 1));

  // Tick evaluation of one lock; a pulse ending now starts its cooldown at now_ms.
  assign ev_fs = fs_vec[idx_q];
  assign pel   = cmd_q.now_ms - pst_q[idx_q];
  assign cel   = cmd_q.now_ms - cst_q[idx_q];
  assign pdone = ev_fs && pact_q[idx_q] && (pel >= 32'(plen_q));
  assign cdone = ev_fs && (pdone ? (clen_q == '0)
                                 : (cact_q[idx_q] && (cel >= 32'(clen_q))));

  always_comb begin
    for (int j = 0; j < L; j++) begin
      above[j] = (IDX_W'(j) > idx_q);
    end
  end

  assign ev_here = sub_q ? cmask_q[idx_q] : pmask_q[idx_q];
  assign more    = (!sub_q && cmask_q[idx_q]) || (|((pmask_q | cmask_q) & above));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sub_d      = sub_q;
    pmask_d    = pmask_q;
    cmask_d    = cmask_q;
    reason_d   = reason_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == lpcc_pkg::CMD_TICK) begin
            state_d = S_EVAL;
            idx_d   = '0;
            sub_d   = 1'b0;
            pmask_d = '0;
            cmask_d = '0;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        unique case (cmd_q.kind)
          lpcc_pkg::CMD_OPEN:
            reason_d = (exec_fs && exec_busy) ? lpcc_pkg::REASON_BUSY : lpcc_pkg::REASON_OPEN;
          lpcc_pkg::CMD_CLOSE:      reason_d = lpcc_pkg::REASON_CLOSE;
          lpcc_pkg::CMD_DISABLED:   reason_d = lpcc_pkg::REASON_DISABLED;
          lpcc_pkg::CMD_WRONG_MODE: reason_d = lpcc_pkg::REASON_WRONG_MODE;
          default:                  reason_d = reason_q;
        endcase
        state_d = S_CMD_OUT;
      end
      S_CMD_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_EVAL: begin
        pmask_d[idx_q] = pdone;
        cmask_d[idx_q] = cdone;
        if (at_end) begin
          idx_d = '0;
          sub_d = 1'b0;
          state_d = ((|(pmask_q | cmask_q)) || pdone || cdone) ? S_EMIT : S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (ev_here && res_full_i) begin
          state_d = S_EMIT;
        end else begin
          res_push_o = ev_here;
          if (ev_here && !more) begin
            state_d = S_IDLE;
          end else if (!sub_q) begin
            sub_d = 1'b1;
          end else begin
            sub_d = 1'b0;
            if (at_end) begin
              state_d = S_IDLE;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Report fields always come from state after the whole request has been applied.
  always_comb begin
    res_o.coil_on     = coil_q[rd_idx];
    res_o.pulse_total = pcnt_q[rd_idx];
    res_o.coil_levels = 8'(coil_q);
    if (state_q == S_EMIT) begin
      res_o.event_lock  = 3'(idx_q);
      res_o.reason_code = sub_q ? lpcc_pkg::REASON_COOLDOWN_DONE : lpcc_pkg::REASON_PULSE_DONE;
      res_o.last        = !more;
    end else begin
      res_o.event_lock  = cmd_q.lock;
      res_o.reason_code = reason_q;
      res_o.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      sub_q    <= 1'b0;
      pmask_q  <= '0;
      cmask_q  <= '0;
      reason_q <= lpcc_pkg::REASON_OPEN;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      sub_q    <= sub_d;
      pmask_q  <= pmask_d;
      cmask_q  <= cmask_d;
      reason_q <= reason_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= lpcc_pkg::PULSE_LEN_RESET;
      clen_q <= lpcc_pkg::COOLDOWN_LEN_RESET;
      fsm_q  <= lpcc_pkg::FS_MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpcc_pkg::CFG_PULSE_LEN:    plen_q <= cfg_wdata_i;
        lpcc_pkg::CFG_COOLDOWN_LEN: clen_q <= cfg_wdata_i;
        lpcc_pkg::CFG_FS_MASK:      fsm_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coil_q <= '0;
      pact_q <= '0;
      cact_q <= '0;
      for (int j = 0; j < L; j++) begin
        pcnt_q[j] <= '0;
      end
    end else if (state_q == S_EXEC) begin
      unique case (cmd_q.kind)
        lpcc_pkg::CMD_OPEN: begin
          if (exec_fs) begin
            if (!exec_busy) begin
              coil_q[cmd_idx] <= 1'b1;
              pact_q[cmd_idx] <= 1'b1;
              cact_q[cmd_idx] <= 1'b0;
              pcnt_q[cmd_idx] <= pcnt_q[cmd_idx] + 16'd1;
            end
          end else begin
            coil_q[cmd_idx] <= 1'b0;
            pact_q[cmd_idx] <= 1'b0;
            cact_q[cmd_idx] <= 1'b0;
          end
        end
        lpcc_pkg::CMD_CLOSE: begin
          // A fail-secure close leaves a running cooldown alone.
          coil_q[cmd_idx] <= !exec_fs;
          pact_q[cmd_idx] <= 1'b0;
          if (!exec_fs) begin
            cact_q[cmd_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_EVAL) begin
      if (pdone) begin
        pact_q[idx_q] <= 1'b0;
        coil_q[idx_q] <= 1'b0;
        cact_q[idx_q] <= !cdone;
      end else if (cdone) begin
        cact_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EXEC) && (cmd_q.kind == lpcc_pkg::CMD_OPEN) && exec_fs && !exec_busy) begin
      pst_q[cmd_idx] <= cmd_q.now_ms;
    end
    if ((state_q == S_EVAL) && pdone) begin
      cst_q[idx_q] <= cmd_q.now_ms;
    end
  end

  `LPCC_ASSERT_NEVER(a_pulse_without_coil, |(pact_q & ~coil_q), "pulse active with coil off")
  `LPCC_ASSERT_NEVER(a_pulse_and_cooldown, |(pact_q & cact_q), "pulse and cooldown both active")
  `LPCC_ASSERT(a_no_report_in_eval, (state_q == S_EVAL) |-> !res_push_o, "report during evaluation")

endmodule

>>> rtl/core/lock_pulse_cooldown_controller.sv
// Top level of the lock pulse/cooldown controller.
// Depends on lpcc_pkg, lpcc_fifo, lpcc_front and lpcc_back.
//
// Usage: requests enter through a queue-style port (push/full) and reports
// leave through another (empty/pop). A request is taken at a clock edge with
// push high and full low; the oldest report sits on res_item_o while empty is
// low and is taken at an edge with pop high. Configuration registers are
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write them
// only while no request is in flight; the block itself does not enforce this.
// A command to a missing lock gives no report. An open, close or rejected
// command passes from idle through the exec and report-out states and gives
// one report. A tick first visits every lock in turn to update its timers,
// then walks the locks again emitting reports, pulse done before cooldown
// done for each lock, up to the lock of its last event. The executor works on
// one request at a time and takes no new one until the last is done; a tick
// with no expiring timer gives no report. A two-entry request queue and a
// two-entry report queue let each side stall on its own; while the report queue
// is full the executor waits and the request queue fills. Reset clears all lock
// state, pulse counts and queues and restores the register defaults.
module lock_pulse_cooldown_controller #(
  parameter int unsigned NUM_LOCKS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  lpcc_pkg::in_item_t               in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output lpcc_pkg::res_item_t              res_item_o,
  input  logic                             cfg_we_i,
  input  logic [lpcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpcc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned RES_W = $bits(lpcc_pkg::res_item_t);

  lpcc_pkg::cmd_t      cmd;
  logic                cmd_empty;
  logic                cmd_pop;
  lpcc_pkg::res_item_t res;
  logic                res_push;
  logic                res_full;
  logic [RES_W-1:0]    res_rdata;

  // Front end: drops commands to missing locks and classifies the rest.
  lpcc_front #(
    .NUM_LOCKS (NUM_LOCKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  // Executor: lock state, timers and report generation.
  lpcc_back #(
    .NUM_LOCKS (NUM_LOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Report queue decouples the executor from a stalling receiver.
  lpcc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_item_o = lpcc_pkg::res_item_t'(res_rdata);

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for lock_pulse_cooldown_controller.
// Depends on lpcc_pkg and the RTL of the block; it predicts every report in a
// small scoreboard class and drives the queue-style ports from plain tasks.
`timescale 1ns / 100ps

module tb_top;
  import lpcc_pkg::*;

  // Scoreboard: keeps its own copy of the lock timers, coil levels and pulse
  // counts, and turns every accepted request into the reports it must cause.
  class coil_report_board;
    logic [15:0] pulse_len;
    logic [15:0] cool_len;
    logic [7:0]  fs_mask;
    logic        coil[8];
    logic        pulsing[8];
    logic        cooling[8];
    logic [31:0] pulse_t0[8];
    logic [31:0] cool_t0[8];
    logic [15:0] fired[8];
    res_item_t   expected_reports[$];
    int          errors;

    function new();
      pulse_len = PULSE_LEN_RESET;
      cool_len  = COOLDOWN_LEN_RESET;
      fs_mask   = FS_MASK_RESET;
      errors    = 0;
      for (int i = 0; i < 8; i++) begin
        coil[i]     = 1'b0;
        pulsing[i]  = 1'b0;
        cooling[i]  = 1'b0;
        pulse_t0[i] = '0;
        cool_t0[i]  = '0;
        fired[i]    = '0;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PULSE_LEN:    pulse_len = data;
        CFG_COOLDOWN_LEN: cool_len  = data;
        CFG_FS_MASK:      fs_mask   = data[7:0];
        default: ;
      endcase
    endfunction

    // Reports carry the coil state as it stands after the whole request.
    function void expect_report(logic [2:0] lk, logic [2:0] why, logic fin);
      res_item_t r;
      r.event_lock  = lk;
      r.reason_code = why;
      r.coil_on     = coil[lk];
      r.pulse_total = fired[lk];
      for (int i = 0; i < 8; i++) r.coil_levels[i] = coil[i];
      r.last        = fin;
      expected_reports.push_back(r);
    endfunction

    function void note_request(in_item_t rq);
      logic [2:0]  ev_lock[16];
      logic [2:0]  ev_why[16];
      logic [31:0] elapsed;
      logic [2:0]  lk;
      logic [2:0]  why;
      int          n;
      n  = 0;
      lk = rq.lock_index;
      if (rq.op == OP_TICK) begin
        // A tick ignores the enable and walks the fail-secure locks in order.
        for (int i = 0; i < 8; i++) begin
          if (!fs_mask[i]) continue;
          elapsed = rq.now_ms - pulse_t0[i];
          if (pulsing[i] && elapsed >= {16'd0, pulse_len}) begin
            pulsing[i] = 1'b0;
            coil[i]    = 1'b0;
            cooling[i] = 1'b1;
            cool_t0[i] = rq.now_ms;
            ev_lock[n] = 3'(i);
            ev_why[n]  = REASON_PULSE_DONE;
            n++;
          end
          // A cooldown that just started can end at once when its length is zero.
          elapsed = rq.now_ms - cool_t0[i];
          if (cooling[i] && elapsed >= {16'd0, cool_len}) begin
            cooling[i] = 1'b0;
            ev_lock[n] = 3'(i);
            ev_why[n]  = REASON_COOLDOWN_DONE;
            n++;
          end
        end
        for (int k = 0; k < n; k++) expect_report(ev_lock[k], ev_why[k], k == n - 1);
        return;
      end
      if (!rq.node_enabled) begin
        why = REASON_DISABLED;
      end else begin
        case (rq.op)
          OP_OPEN: begin
            if (fs_mask[lk]) begin
              if (pulsing[lk] || cooling[lk]) begin
                why = REASON_BUSY;
              end else begin
                coil[lk]     = 1'b1;
                pulsing[lk]  = 1'b1;
                cooling[lk]  = 1'b0;
                pulse_t0[lk] = rq.now_ms;
                fired[lk]    = fired[lk] + 16'd1;
                why          = REASON_OPEN;
              end
            end else begin
              coil[lk]    = 1'b0;
              pulsing[lk] = 1'b0;
              cooling[lk] = 1'b0;
              why         = REASON_OPEN;
            end
          end
          OP_CLOSE: begin
            // On a fail-secure lock a running cooldown is left alone.
            coil[lk]    = !fs_mask[lk];
            pulsing[lk] = 1'b0;
            if (!fs_mask[lk]) cooling[lk] = 1'b0;
            why = REASON_CLOSE;
          end
          default: why = REASON_WRONG_MODE;
        endcase
      end
      expect_report(lk, why, 1'b1);
    endfunction

    task log_mismatch(string msg);
      errors++;
      $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    task check_report(res_item_t got);
      res_item_t want;
      if (expected_reports.size() == 0) begin
        log_mismatch($sformatf("report with none pending: %h", got));
        return;
      end
      want = expected_reports.pop_front();
      if (got.event_lock !== want.event_lock)
        log_mismatch($sformatf("event_lock got %0d want %0d", got.event_lock, want.event_lock));
      if (got.reason_code !== want.reason_code)
        log_mismatch($sformatf("reason_code got %0d want %0d", got.reason_code,
                               want.reason_code));
      if (got.coil_on !== want.coil_on)
        log_mismatch($sformatf("coil_on got %b want %b", got.coil_on, want.coil_on));
      if (got.pulse_total !== want.pulse_total)
        log_mismatch($sformatf("pulse_total got %0d want %0d", got.pulse_total,
                               want.pulse_total));
      if (got.coil_levels !== want.coil_levels)
        log_mismatch($sformatf("coil_levels got %b want %b", got.coil_levels,
                               want.coil_levels));
      if (got.last !== want.last)
        log_mismatch($sformatf("last got %b want %b", got.last, want.last));
    endtask

    task flush_leftovers();
      while (expected_reports.size() != 0)
        log_mismatch($sformatf("report never arrived: %h", expected_reports.pop_front()));
    endtask
  endclass

  localparam int PHASES        = 7;
  localparam int RAND_PER_PHASE = 52;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  in_item_t              in_item;
  logic                  empty;
  logic                  pop;
  res_item_t             res_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  coil_report_board board;

  // Shared between the request and report processes: calm turns idling off on
  // both sides, hold_req asks the report side for one long stall.
  logic        calm;
  logic        hold_req;
  logic [31:0] stamp;

  lock_pulse_cooldown_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .res_item_o  (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] op, logic [2:0] lk, logic [31:0] t, logic en);
    in_item_t rq;
    rq.op           = op;
    rq.lock_index   = lk;
    rq.now_ms       = t;
    rq.node_enabled = en;
    return rq;
  endfunction

  // Offers one request from a falling edge and returns at the falling edge
  // after it was taken. Random idle cycles come first unless calm is set.
  task automatic send(in_item_t rq);
    while (!calm && $urandom_range(0, 99) < 15) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push    = 1'b1;
    in_item = rq;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_request(rq);
    @(negedge clk_i);
  endtask

  // Registers change only with nothing in flight. A tick without events
  // leaves no trace in the pending count, so a quiet stretch follows.
  task automatic wait_quiet();
    push = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_config(logic [15:0] plen, logic [15:0] clen, logic [7:0] mask);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_PULSE_LEN;
    cfg_wdata = plen;
    board.set_config(CFG_PULSE_LEN, plen);
    @(negedge clk_i);
    cfg_idx   = CFG_COOLDOWN_LEN;
    cfg_wdata = clen;
    board.set_config(CFG_COOLDOWN_LEN, clen);
    @(negedge clk_i);
    cfg_idx   = CFG_FS_MASK;
    cfg_wdata = {8'd0, mask};
    board.set_config(CFG_FS_MASK, {8'd0, mask});
    @(negedge clk_i);
    cfg_we = 1'b0;
    @(negedge clk_i);
  endtask

  // Hand-picked sequence for the configuration 10 / 20 / 8'hA5, where locks
  // 0, 2, 5 and 7 are fail-secure and the rest are fail-safe.
  task automatic directed_requests();
    send(mk(OP_OPEN, 3'd0, 32'd100, 1'b1));
    send(mk(OP_OPEN, 3'd0, 32'd101, 1'b1));          // busy while pulsing
    send(mk(OP_TICK, 3'd0, 32'd105, 1'b1));          // pulse still running
    send(mk(OP_TICK, 3'd0, 32'd110, 1'b1));          // pulse ends, cooldown starts
    send(mk(OP_OPEN, 3'd0, 32'd115, 1'b1));          // busy while cooling down
    send(mk(OP_TICK, 3'd5, 32'd130, 1'b1));          // cooldown ends
    send(mk(OP_OPEN, 3'd0, 32'd131, 1'b1));
    send(mk(OP_CLOSE, 3'd0, 32'd132, 1'b1));         // close cuts the pulse short
    send(mk(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1));
    send(mk(OP_OPEN, 3'd1, 32'd0, 1'b1));            // fail-safe open drops the coil
    send(mk(OP_CLOSE, 3'd1, 32'd1, 1'b1));           // fail-safe close raises it
    send(mk(OP_OPEN, 3'd7, 32'd2, 1'b0));            // node disabled
    send(mk(OP_UNKNOWN, 3'd3, 32'd3, 1'b1));         // unknown command
    send(mk(OP_UNKNOWN, 3'd4, 32'd3, 1'b0));         // unknown command while disabled
    send(mk(OP_CLOSE, 3'd6, 32'd4, 1'b0));
    send(mk(OP_TICK, 3'd2, 32'd0, 1'b0));            // ticks run even when disabled
    send(mk(OP_OPEN, 3'd2, 32'd1000, 1'b1));
    send(mk(OP_OPEN, 3'd5, 32'd1000, 1'b1));
    send(mk(OP_CLOSE, 3'd5, 32'd1003, 1'b1));
    send(mk(OP_OPEN, 3'd7, 32'hFFFF_FFF8, 1'b1));
    send(mk(OP_TICK, 3'd0, 32'd5, 1'b1));            // time wraps, two pulses end
    send(mk(OP_CLOSE, 3'd2, 32'd6, 1'b1));           // cooldown keeps running
    send(mk(OP_OPEN, 3'd2, 32'd7, 1'b1));            // so this one is busy
    send(mk(OP_TICK, 3'd0, 32'd30, 1'b1));           // both cooldowns end
    send(mk(OP_CLOSE, 3'd3, 32'd31, 1'b1));
  endtask

  // Random traffic: time mostly moves forward in steps sized to the timers so
  // pulses and cooldowns expire, with an occasional jump anywhere.
  task automatic random_requests(int count, int unsigned span);
    int unsigned pick;
    logic [1:0]  op;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 3) stamp = $urandom();
      else stamp = stamp + $urandom_range(0, span);
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_TICK;
      else if (pick < 72) op = OP_OPEN;
      else if (pick < 92) op = OP_CLOSE;
      else                op = OP_UNKNOWN;
      send(mk(op, 3'($urandom_range(0, 7)), stamp, $urandom_range(0, 99) >= 8));
    end
  endtask

  // Report side: pops with random stalls, and once stalls for a long stretch
  // so the report queue and then the request queue fill up.
  initial begin
    int hold_left;
    hold_left = 0;
    pop       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = calm || ($urandom_range(0, 99) >= 15);
      end
      @(posedge clk_i);
      if (pop && !empty) board.check_report(res_item);
    end
  end

  initial begin
    logic [15:0] ph_plen[PHASES];
    logic [15:0] ph_clen[PHASES];
    logic [7:0]  ph_mask[PHASES];
    int          guard;
    ph_plen   = '{16'd10, 16'd1, 16'd65535, 16'd0, 16'd500, 16'd37, 16'd300};
    ph_clen   = '{16'd20, 16'd0, 16'd65535, 16'd5, 16'd1000, 16'd0, 16'd300};
    ph_mask   = '{8'hA5, 8'hFF, 8'h0F, 8'h3C, 8'hFF, 8'h00, 8'h00};
    board     = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    stamp     = '0;
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PULSE_LEN;
    cfg_wdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 5) begin
        ph_plen[p] = 16'($urandom_range(1, 300));
        ph_clen[p] = 16'($urandom_range(0, 300));
        ph_mask[p] = 8'($urandom());
      end
      wait_quiet();
      write_config(ph_plen[p], ph_clen[p], ph_mask[p]);
      if (p == 0) directed_requests();
      stamp = (p == 2) ? 32'hFFFF_8000 : $urandom();
      calm  = (p == 1);
      if (p == 3) hold_req = 1'b1;
      random_requests(RAND_PER_PHASE, (ph_plen[p] + ph_clen[p]) / 3 + 2);
      calm = 1'b0;
    end

    push  = 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    board.flush_leftovers();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lpcc_pkg.sv
rtl/core/lpcc_fifo.sv
rtl/core/lpcc_front.sv
rtl/core/lpcc_back.sv
rtl/core/lock_pulse_cooldown_controller.sv
verif/tb_top.sv
